FILE: hdl/svl_pkg.sv
// ----------------------------------------------------------------------------
// svl_pkg: shared types and constants for the state variable lowpass
// Formats, multiplier operand codes, the controller-to-datapath command and
// status bundles, and the saturation helpers.
// ----------------------------------------------------------------------------
package svl_pkg;

  localparam int unsigned DATA_W  = 16;  // Q1.15 sample and output
  localparam int unsigned ACC_W   = 24;  // Q4.20 integrators
  localparam int unsigned COEF_W  = 17;  // clamped Q15 coefficient, 0..32768
  localparam int unsigned MUL_A_W = 27;  // band or high operand
  localparam int unsigned MUL_B_W = 18;  // coefficient or damping operand
  localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;

  localparam logic [COEF_W-1:0]         F_ONE   = 17'd32768;
  localparam logic [COEF_W-1:0]         F_RESET = 17'd5457;
  localparam logic signed [MUL_B_W-1:0] DAMP    = 18'sd22938;  // 1.4 in Q4.14

  typedef logic [1:0] mul_sel_t;
  localparam mul_sel_t MUL_BF = 2'd0;  // band * f
  localparam mul_sel_t MUL_BD = 2'd1;  // band * damping
  localparam mul_sel_t MUL_FH = 2'd2;  // f * high

  typedef struct packed {
    logic     take_in;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     low_upd;
    logic     high_upd;
    logic     out_load;
    logic     band_upd;
  } svl_cmd_t;

  typedef struct packed {
    logic out_free;
  } svl_stat_t;

  function automatic logic signed [ACC_W-1:0] sat24(input logic signed [31:0] x);
    logic signed [ACC_W-1:0] r;
    if (x > 32'sd8388607) begin
      r = 24'sh7FFFFF;
    end else if (x < -32'sd8388608) begin
      r = 24'sh800000;
    end else begin
      r = x[ACC_W-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [DATA_W-1:0] sat16(input logic signed [31:0] x);
    logic signed [DATA_W-1:0] r;
    if (x > 32'sd32767) begin
      r = 16'sh7FFF;
    end else if (x < -32'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = x[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

FILE: hdl/state_variable_lowpass.sv
// ----------------------------------------------------------------------------
// state_variable_lowpass: Chamberlin state variable filter, lowpass output
// Q1.15 samples in, saturated Q1.15 lowpass out; Q4.20 saturating
// integrators, fixed damping of 1.4, Q15 frequency coefficient register.
//
//   channel   signals                          direction  payload
//   cfg       cfg_valid / cfg_ready            in         freq_coeff [15:0]
//   in        in_valid / in_ready              in         sample_in  [15:0] signed
//   out       out_valid / out_ready            out        lowpass_out[15:0] signed
//
// A new sample is taken only once the last one is through its step: three
// products go through the single shared 27x18 multiplier, one after the other.
// The result leaves from an output register, loaded after the lowpass update.
// A stalled output stops the step only when the next result is ready to load.
// Reset clears both integrators and loads the coefficient with 5457.
// Coefficient writes are always taken; values above 32768 act as 32768.
// ----------------------------------------------------------------------------
module state_variable_lowpass (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] freq_coeff,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic signed [15:0] sample_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [15:0] lowpass_out
);

  svl_pkg::svl_cmd_t  cmd;
  svl_pkg::svl_stat_t stat;

  assign cfg_ready = 1'b1;

  svl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  svl_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .sample_in   (sample_in),
    .cfg_valid   (cfg_valid),
    .freq_coeff  (freq_coeff),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .lowpass_out (lowpass_out)
  );

endmodule

FILE: hdl/svl_ctrl.sv
// ----------------------------------------------------------------------------
// svl_ctrl: sequencer for one filter step
// Walks one sample through the shared multiplier: band*f, lowpass update
// with band*damping, high term and output load, f*high, bandpass update.
// ----------------------------------------------------------------------------
module svl_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  svl_pkg::svl_stat_t   stat,
  output svl_pkg::svl_cmd_t    cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOW  = 3'd1;
  localparam logic [2:0] S_HIGH = 3'd2;
  localparam logic [2:0] S_MFH  = 3'd3;
  localparam logic [2:0] S_BAND = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.mul_sel = svl_pkg::MUL_BF;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take_in = 1'b1;
          cmd.mul_en  = 1'b1;
          cmd.mul_sel = svl_pkg::MUL_BF;
          state_next  = S_LOW;
        end
      end
      S_LOW: begin
        cmd.low_upd = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = svl_pkg::MUL_BD;
        state_next  = S_HIGH;
      end
      S_HIGH: begin
        // hold until the output register is free
        if (stat.out_free) begin
          cmd.high_upd = 1'b1;
          cmd.out_load = 1'b1;
          state_next   = S_MFH;
        end
      end
      S_MFH: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = svl_pkg::MUL_FH;
        state_next  = S_BAND;
      end
      S_BAND: begin
        cmd.band_upd = 1'b1;
        state_next   = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: hdl/svl_dp.sv
// ----------------------------------------------------------------------------
// svl_dp: filter datapath
// Integrators, coefficient register, one shared registered multiplier,
// rounding and saturation, and the output register.
// ----------------------------------------------------------------------------
module svl_dp (
  input  logic                               clk,
  input  logic                               rst,
  input  svl_pkg::svl_cmd_t                  cmd,
  output svl_pkg::svl_stat_t                 stat,
  input  logic signed [svl_pkg::DATA_W-1:0]  sample_in,
  input  logic                               cfg_valid,
  input  logic [15:0]                        freq_coeff,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [svl_pkg::DATA_W-1:0]  lowpass_out
);

  logic signed [svl_pkg::ACC_W-1:0]   low;
  logic signed [svl_pkg::ACC_W-1:0]   band;
  logic        [svl_pkg::COEF_W-1:0]  f;
  logic signed [svl_pkg::DATA_W-1:0]  sample;
  logic signed [svl_pkg::PROD_W-1:0]  prod;
  logic signed [svl_pkg::MUL_A_W-1:0] high;

  logic signed [svl_pkg::MUL_A_W-1:0] mul_a;
  logic signed [svl_pkg::MUL_B_W-1:0] mul_b;
  logic signed [svl_pkg::PROD_W-1:0]  rsum15;
  logic signed [svl_pkg::PROD_W-1:0]  rsum14;
  logic signed [29:0]                 rnd15;
  logic signed [30:0]                 damp_r;
  logic signed [31:0]                 low_sum;
  logic signed [31:0]                 band_sum;
  logic signed [31:0]                 high_full;
  logic signed [24:0]                 rsum5;
  logic signed [19:0]                 rnd5;

  // operand select for the shared multiplier
  always_comb begin
    unique case (cmd.mul_sel)
      svl_pkg::MUL_BD: begin
        mul_a = {{3{band[23]}}, band};
        mul_b = svl_pkg::DAMP;
      end
      svl_pkg::MUL_FH: begin
        mul_a = high;
        mul_b = {1'b0, f};
      end
      default: begin
        mul_a = {{3{band[23]}}, band};
        mul_b = {1'b0, f};
      end
    endcase
  end

  // round half up, then floor shift
  assign rsum15 = prod + 45'sd16384;
  assign rnd15  = rsum15[44:15];
  assign rsum14 = prod + 45'sd8192;
  assign damp_r = rsum14[44:14];

  assign low_sum   = {{8{low[23]}}, low} + {{2{rnd15[29]}}, rnd15};
  assign band_sum  = {{8{band[23]}}, band} + {{2{rnd15[29]}}, rnd15};
  assign high_full = {{11{sample[15]}}, sample, 5'b0} - {{8{low[23]}}, low}
                     - {damp_r[30], damp_r};

  assign rsum5 = {low[23], low} + 25'sd16;
  assign rnd5  = rsum5[24:5];

  always_ff @(posedge clk) begin
    if (rst) begin
      low  <= '0;
      band <= '0;
      f    <= svl_pkg::F_RESET;
    end else begin
      if (cfg_valid) begin
        // clamp the coefficient to one
        if ({1'b0, freq_coeff} > svl_pkg::F_ONE) begin
          f <= svl_pkg::F_ONE;
        end else begin
          f <= {1'b0, freq_coeff};
        end
      end
      if (cmd.low_upd) begin
        low <= svl_pkg::sat24(low_sum);
      end
      if (cmd.band_upd) begin
        band <= svl_pkg::sat24(band_sum);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_in) begin
      sample <= sample_in;
    end
    if (cmd.mul_en) begin
      prod <= mul_a * mul_b;
    end
    if (cmd.high_upd) begin
      high <= high_full[svl_pkg::MUL_A_W-1:0];
    end
    if (cmd.out_load) begin
      lowpass_out <= svl_pkg::sat16({{12{rnd5[19]}}, rnd5});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign stat.out_free = !out_valid || out_ready;

  a_coeff_clamped: assert property (@(posedge clk) disable iff (rst)
    f <= svl_pkg::F_ONE)
    else $error("coefficient above one");

  a_out_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("output overwritten before it was taken");

  a_low_after_bf: assert property (@(posedge clk) disable iff (rst)
    cmd.low_upd |-> $past(cmd.mul_en && cmd.mul_sel == svl_pkg::MUL_BF))
    else $error("lowpass update without band*f product");

  a_band_after_fh: assert property (@(posedge clk) disable iff (rst)
    cmd.band_upd |-> $past(cmd.mul_en && cmd.mul_sel == svl_pkg::MUL_FH))
    else $error("bandpass update without f*high product");

endmodule
